// ===== hw/rtl/gpe_pkg.sv =====
// Shared types and constants of the Goldbach partition enumerator.
// Used by the front end, the back end and the core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package gpe_pkg;

	// Default parameter values.
	localparam int NUMBER_WIDTH_DEF = 10;
	localparam int MAX_PAIRS_DEF    = 64;

	// Smallest number that is split, and the first candidate prime.
	localparam int MIN_NUMBER   = 6;
	localparam int FIRST_PRIME  = 2;
	localparam int FIRST_SQUARE = FIRST_PRIME * FIRST_PRIME;

	// Result status codes.
	localparam logic [1:0] ST_PAIR  = 2'd0;
	localparam logic [1:0] ST_SMALL = 2'd1;
	localparam logic [1:0] ST_ODD   = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	// Classification of an accepted number.
	typedef enum logic [1:0] {
		KIND_EVEN,
		KIND_SMALL,
		KIND_ODD
	} kind_t;

	// Control of the command queue between front and back.
	typedef struct packed {
		logic  valid;
		kind_t kind;
	} cmd_ctl_t;

	// Back end sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_REJ,
		S_CAND,
		S_TEST,
		S_MOD,
		S_FOUND,
		S_FLUSH
	} back_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gpe_mod.sv =====
// Iterative remainder unit: one dividend bit per cycle, restoring scheme.
// Does not depend on gpe_pkg; stands alone.
`timescale 1ns / 1ps
`default_nettype none

module gpe_mod #(
	parameter int NUMBER_WIDTH = 10
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic [NUMBER_WIDTH-1:0] dividend,
	input  wire logic [NUMBER_WIDTH-1:0] divisor,
	output logic                         done,
	output logic [NUMBER_WIDTH-1:0]      rem
);

	localparam int STEP_W = $clog2(NUMBER_WIDTH);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUMBER_WIDTH - 1);

	logic                    busy_q;
	logic                    done_q;
	logic [STEP_W-1:0]       step_q;
	logic [NUMBER_WIDTH-1:0] rem_q;
	logic [NUMBER_WIDTH-1:0] shift_q;
	logic [NUMBER_WIDTH-1:0] div_q;
	logic [NUMBER_WIDTH:0]   trial;
	logic [NUMBER_WIDTH:0]   trial_sub;
	logic [NUMBER_WIDTH-1:0] rem_next;

	// Bring in the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial     = {rem_q, shift_q[NUMBER_WIDTH-1]};
		trial_sub = trial - {1'b0, div_q};
		if (trial >= {1'b0, div_q}) begin
			rem_next = trial_sub[NUMBER_WIDTH-1:0];
		end else begin
			rem_next = trial[NUMBER_WIDTH-1:0];
		end
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	// Partial remainder and dividend shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
			div_q   <= divisor;
		end else if (busy_q) begin
			rem_q   <= rem_next;
			shift_q <= {shift_q[NUMBER_WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/gpe_front.sv =====
// Front end: classifies each accepted number and holds it in a two-entry queue.
// Depends on gpe_pkg for the classification type and constants.
`timescale 1ns / 1ps
`default_nettype none

module gpe_front
	import gpe_pkg::*;
#(
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [NUMBER_WIDTH-1:0] number,
	output cmd_ctl_t                     cmd,
	output logic [NUMBER_WIDTH-1:0]      cmd_number,
	input  wire logic                    cmd_pop
);

	logic [NUMBER_WIDTH-1:0] num_q [2];
	kind_t                   kind_q [2];
	logic                    wr_q;
	logic                    rd_q;
	logic [1:0]              cnt_q;
	kind_t                   kind_in;
	logic                    do_push;
	logic                    do_pop;

	// Small numbers are rejected before the odd test.
	always_comb begin
		if (number < NUMBER_WIDTH'(MIN_NUMBER)) begin
			kind_in = KIND_SMALL;
		end else if (number[0]) begin
			kind_in = KIND_ODD;
		end else begin
			kind_in = KIND_EVEN;
		end
	end

	assign full    = (cnt_q == 2'd2);
	assign do_push = push && !full;
	assign do_pop  = cmd_pop && (cnt_q != 2'd0);

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			num_q[wr_q]  <= number;
			kind_q[wr_q] <= kind_in;
		end
	end

	assign cmd.valid  = (cnt_q != 2'd0);
	assign cmd.kind   = kind_q[rd_q];
	assign cmd_number = num_q[rd_q];

endmodule

`default_nettype wire

// ===== hw/rtl/gpe_back.sv =====
// Back end: walks the candidates of one number, tests both parts by trial
// division through gpe_mod, and queues results. Depends on gpe_pkg and gpe_mod.
`timescale 1ns / 1ps
`default_nettype none

module gpe_back
	import gpe_pkg::*;
#(
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
	parameter int MAX_PAIRS    = MAX_PAIRS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_ctl_t                cmd,
	input  wire logic [NUMBER_WIDTH-1:0] cmd_number,
	output logic                         cmd_pop,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [NUMBER_WIDTH-1:0]      smaller_prime,
	output logic [NUMBER_WIDTH-1:0]      larger_prime,
	output logic [1:0]                   status,
	output logic                         last
);

	localparam int CNT_W = $clog2(MAX_PAIRS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAIRS);

	// Sequencer control state.
	back_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic pend_v_q, pend_v_d;
	logic trunc_q, trunc_d;
	logic phase_q, phase_d;

	// Walk datapath.
	logic [NUMBER_WIDTH-1:0] n_q, n_d;
	logic [1:0]              rej_st_q, rej_st_d;
	logic [NUMBER_WIDTH-1:0] p_q, p_d;
	logic [NUMBER_WIDTH-1:0] v_q, v_d;
	logic [NUMBER_WIDTH-1:0] d_q, d_d;
	logic [NUMBER_WIDTH:0]   sq_q, sq_d;
	logic [NUMBER_WIDTH-1:0] pend_p_q, pend_p_d;
	logic [NUMBER_WIDTH-1:0] pend_r_q, pend_r_d;

	logic [NUMBER_WIDTH-1:0] half;
	logic [NUMBER_WIDTH-1:0] n_minus_p;
	logic                    mod_start;
	logic                    mod_done;
	logic [NUMBER_WIDTH-1:0] mod_rem;

	// Result queue.
	logic [NUMBER_WIDTH-1:0] oq_small_q [2];
	logic [NUMBER_WIDTH-1:0] oq_large_q [2];
	logic [1:0]              oq_status_q [2];
	logic                    oq_last_q [2];
	logic                    oq_wr_q;
	logic                    oq_rd_q;
	logic [1:0]              oq_cnt_q;
	logic                    oq_full;
	logic                    oq_push;
	logic                    oq_pop;
	logic [NUMBER_WIDTH-1:0] oq_small;
	logic [NUMBER_WIDTH-1:0] oq_large;
	logic [1:0]              oq_status;
	logic                    oq_last;

	assign half      = n_q >> 1;
	assign n_minus_p = n_q - p_q;
	assign oq_full   = (oq_cnt_q == 2'd2);

	// Shared remainder unit for every trial division.
	gpe_mod #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (v_q),
		.divisor  (d_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// Next state and sequencer outputs.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pend_v_d  = pend_v_q;
		trunc_d   = trunc_q;
		phase_d   = phase_q;
		n_d       = n_q;
		rej_st_d  = rej_st_q;
		p_d       = p_q;
		v_d       = v_q;
		d_d       = d_q;
		sq_d      = sq_q;
		pend_p_d  = pend_p_q;
		pend_r_d  = pend_r_q;
		cmd_pop   = 1'b0;
		mod_start = 1'b0;
		oq_push   = 1'b0;
		oq_small  = pend_p_q;
		oq_large  = pend_r_q;
		oq_status = ST_PAIR;
		oq_last   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					cmd_pop = 1'b1;
					n_d     = cmd_number;
					if (cmd.kind == KIND_EVEN) begin
						p_d      = NUMBER_WIDTH'(FIRST_PRIME);
						cnt_d    = '0;
						pend_v_d = 1'b0;
						trunc_d  = 1'b0;
						state_d  = S_CAND;
					end else begin
						rej_st_d = (cmd.kind == KIND_SMALL) ? ST_SMALL : ST_ODD;
						state_d  = S_REJ;
					end
				end
			end
			S_REJ: begin
				if (!oq_full) begin
					oq_push   = 1'b1;
					oq_small  = '0;
					oq_large  = '0;
					oq_status = rej_st_q;
					oq_last   = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_CAND: begin
				if (p_q > half) begin
					state_d = S_FLUSH;
				end else begin
					v_d     = p_q;
					phase_d = 1'b0;
					d_d     = NUMBER_WIDTH'(FIRST_PRIME);
					sq_d    = (NUMBER_WIDTH + 1)'(FIRST_SQUARE);
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (v_q < NUMBER_WIDTH'(FIRST_PRIME)) begin
					p_d     = p_q + 1'b1;
					state_d = S_CAND;
				end else if (sq_q > {1'b0, v_q}) begin
					// No divisor up to the square root: the value is prime.
					if (!phase_q) begin
						v_d     = n_minus_p;
						phase_d = 1'b1;
						d_d     = NUMBER_WIDTH'(FIRST_PRIME);
						sq_d    = (NUMBER_WIDTH + 1)'(FIRST_SQUARE);
					end else begin
						state_d = S_FOUND;
					end
				end else begin
					mod_start = 1'b1;
					state_d   = S_MOD;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					if (mod_rem == '0) begin
						p_d     = p_q + 1'b1;
						state_d = S_CAND;
					end else begin
						// (d + 1)^2 = d^2 + 2d + 1.
						d_d     = d_q + 1'b1;
						sq_d    = sq_q + {d_q, 1'b1};
						state_d = S_TEST;
					end
				end
			end
			S_FOUND: begin
				if (cnt_q == CNT_MAX) begin
					trunc_d = 1'b1;
					state_d = S_FLUSH;
				end else if (!(pend_v_q && oq_full)) begin
					// The held pair is not the last one; send it on.
					oq_push  = pend_v_q;
					pend_p_d = p_q;
					pend_r_d = n_minus_p;
					pend_v_d = 1'b1;
					cnt_d    = cnt_q + 1'b1;
					p_d      = p_q + 1'b1;
					state_d  = S_CAND;
				end
			end
			S_FLUSH: begin
				if (!pend_v_q) begin
					state_d = S_IDLE;
				end else if (!oq_full) begin
					oq_push   = 1'b1;
					oq_status = trunc_q ? ST_TRUNC : ST_PAIR;
					oq_last   = 1'b1;
					pend_v_d  = 1'b0;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			trunc_q  <= 1'b0;
			phase_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			pend_v_q <= pend_v_d;
			trunc_q  <= trunc_d;
			phase_q  <= phase_d;
		end
	end

	// Walk datapath registers.
	always_ff @(posedge clk) begin
		n_q      <= n_d;
		rej_st_q <= rej_st_d;
		p_q      <= p_d;
		v_q      <= v_d;
		d_q      <= d_d;
		sq_q     <= sq_d;
		pend_p_q <= pend_p_d;
		pend_r_q <= pend_r_d;
	end

	assign oq_pop = pop && (oq_cnt_q != 2'd0);

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= 1'b0;
			oq_rd_q  <= 1'b0;
			oq_cnt_q <= 2'd0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= ~oq_wr_q;
			end
			if (oq_pop) begin
				oq_rd_q <= ~oq_rd_q;
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 2'd1;
			end else if (!oq_push && oq_pop) begin
				oq_cnt_q <= oq_cnt_q - 2'd1;
			end
		end
	end

	// Result queue storage.
	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_small_q[oq_wr_q]  <= oq_small;
			oq_large_q[oq_wr_q]  <= oq_large;
			oq_status_q[oq_wr_q] <= oq_status;
			oq_last_q[oq_wr_q]   <= oq_last;
		end
	end

	assign empty         = (oq_cnt_q == 2'd0);
	assign smaller_prime = oq_small_q[oq_rd_q];
	assign larger_prime  = oq_large_q[oq_rd_q];
	assign status        = oq_status_q[oq_rd_q];
	assign last          = oq_last_q[oq_rd_q];

`ifndef SYNTHESIS
	// The pair count never passes the limit.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_MAX)
		else $error("pair count above limit");

	// The result queue never overfills.
	assert property (@(posedge clk) disable iff (!arst_n) oq_cnt_q <= 2'd2)
		else $error("result queue overfilled");

	// A held pair always belongs to the counted pairs.
	assert property (@(posedge clk) disable iff (!arst_n) pend_v_q |-> (cnt_q != '0))
		else $error("held pair without count");

	// The remainder unit only reports back while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n) mod_done |-> (state_q == S_MOD))
		else $error("remainder done outside wait state");

	// A division is started only with a divisor of at least two.
	assert property (@(posedge clk) disable iff (!arst_n)
		mod_start |-> (d_q >= NUMBER_WIDTH'(FIRST_PRIME)))
		else $error("trial divisor below two");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/goldbach_partition_enumerator_core.sv =====
// A rejected number passes from the idle state to the reject state once the back end takes it
// from the front queue, and is queued as a result when the result queue has room. An even
// number n is walked over the candidates p <= n/2 with trial divisions of p and n-p in the
// bit-serial remainder unit; one number is worked at a time, two more wait.
// Reset (arst_n low) empties both queues and returns the sequencer to idle at once;
// there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module goldbach_partition_enumerator_core
	import gpe_pkg::*;
#(
	parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF,
	parameter int MAX_PAIRS    = MAX_PAIRS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic [NUMBER_WIDTH-1:0] number,
	output logic                         empty,
	input  wire logic                    pop,
	output logic [NUMBER_WIDTH-1:0]      smaller_prime,
	output logic [NUMBER_WIDTH-1:0]      larger_prime,
	output logic [1:0]                   status,
	output logic                         last
);

	cmd_ctl_t                cmd;
	logic [NUMBER_WIDTH-1:0] cmd_number;
	logic                    cmd_pop;

	// Front end: classification and command queue.
	gpe_front #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.number     (number),
		.cmd        (cmd),
		.cmd_number (cmd_number),
		.cmd_pop    (cmd_pop)
	);

	// Back end: candidate walk, primality tests and result queue.
	gpe_back #(
		.NUMBER_WIDTH(NUMBER_WIDTH),
		.MAX_PAIRS   (MAX_PAIRS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cmd_number    (cmd_number),
		.cmd_pop       (cmd_pop),
		.empty         (empty),
		.pop           (pop),
		.smaller_prime (smaller_prime),
		.larger_prime  (larger_prime),
		.status        (status),
		.last          (last)
	);

endmodule

`default_nettype wire
